@@ src/assert_macros.svh @@
// Assertion macros shared by the cipher block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge outside reset.
`define HCM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hcm check failed");
// Check that nxt holds in the cycle after cond.
`define HCM_ASSERT_NEXT(name, clk, rst, cond, nxt) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("hcm check failed");
`else
`define HCM_ASSERT(name, clk, rst, prop)
`define HCM_ASSERT_NEXT(name, clk, rst, cond, nxt)
`endif
`endif

@@ src/hcm_pkg.sv @@
// Shared constants, types and arithmetic helpers of the mod-26 cipher block.
package hcm_pkg;

   localparam int MaxBlock     = 4;
   localparam int MinBlock     = 2;
   localparam int LetterW      = 5;
   localparam int ProdW        = 2 * LetterW;
   localparam int SizeW        = 3;
   localparam int IdxW         = 2;
   localparam int RowW         = MaxBlock * LetterW;
   localparam int SumW         = 12;
   localparam int CsrIdxW      = 3;
   localparam int SettleW      = 3;
   localparam int SettleCycles = 4;
   localparam int QueueDepth   = 2;
   localparam int QPtrW        = 1;
   localparam int QCntW        = 2;

   // Reciprocal of 26 scaled by 2^16, rounded up; exact quotient below 4096.
   localparam int RecipShift = 16;
   localparam logic [2*SumW-1:0] RecipVal = 2521;
   localparam logic [SumW-1:0]   ModSum   = 26;
   localparam logic [LetterW-1:0] Mod26L  = 26;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_BLOCK_SIZE = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_DECRYPT    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_KEY_ROW0   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_KEY_ROW1   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_KEY_ROW2   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_KEY_ROW3   = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_SIZE   = 2'd1,
      STATUS_NO_INVERSE = 2'd2
   } status_type;

   typedef struct packed {
      logic [MaxBlock-1:0][LetterW-1:0] letters;
      logic [SizeW-1:0]                 size;
   } blk_type;

   typedef struct packed {
      logic [SizeW-1:0] size;
      logic             hold;
   } front_cfg_type;

   // cols[i][j] is matrix entry [j][i]: column i weights letter j.
   typedef struct packed {
      logic [MaxBlock-1:0][MaxBlock-1:0][LetterW-1:0] cols;
      status_type                                     status;
   } key_type;

   function automatic logic [LetterW-1:0] mod26(input logic [SumW-1:0] v);
      logic [2*SumW-1:0] prod;
      logic [SumW-1:0]   quot;
      logic [SumW-1:0]   rem;
      prod = {{SumW{1'b0}}, v} * RecipVal;
      quot = SumW'(prod >> RecipShift);
      rem  = v - (quot * ModSum);
      return LetterW'(rem);
   endfunction

   function automatic logic [LetterW-1:0] red5(input logic [LetterW-1:0] v);
      return (v >= Mod26L) ? (v - Mod26L) : v;
   endfunction

   function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] bs);
      logic [SizeW-1:0] s;
      s = bs;
      if (bs < SizeW'(MinBlock)) s = SizeW'(MinBlock);
      if (bs > SizeW'(MaxBlock)) s = SizeW'(MaxBlock);
      return s;
   endfunction

   // Inverse mod 26; zero where none exists.
   function automatic logic [LetterW-1:0] inv26(input logic [LetterW-1:0] d);
      logic [LetterW-1:0] r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

@@ src/hcm_keyprep.sv @@
// Configuration registers and pipelined derivation of the working key matrix.
module hcm_keyprep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [hcm_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [hcm_pkg::RowW-1:0]          csr_data,
   output hcm_pkg::front_cfg_type            front_cfg,
   output hcm_pkg::key_type                  key
);

   logic [hcm_pkg::SizeW-1:0]                       block_size_ff, block_size_in;
   logic                                            decrypt_ff, decrypt_in;
   logic [hcm_pkg::MaxBlock-1:0][hcm_pkg::RowW-1:0] key_row_ff, key_row_in;
   logic [hcm_pkg::SettleW-1:0]                     settle_ff, settle_in;
   logic [hcm_pkg::ProdW-1:0]                       det_a_ff, det_a_in;
   logic [hcm_pkg::ProdW-1:0]                       det_b_ff, det_b_in;
   logic [hcm_pkg::LetterW-1:0]                     inv_ff, inv_in;
   logic [1:0][1:0][hcm_pkg::ProdW-1:0]             dprod_ff, dprod_in;
   hcm_pkg::key_type                                key_ff, key_in;

   logic [hcm_pkg::LetterW-1:0] k00, k01, k10, k11;
   logic [hcm_pkg::LetterW-1:0] ra, rb, det;
   logic [hcm_pkg::LetterW:0]   det_wrap;
   logic [hcm_pkg::SizeW-1:0]   size_eff;

   assign k00 = key_row_ff[0][0 +: hcm_pkg::LetterW];
   assign k01 = key_row_ff[0][hcm_pkg::LetterW +: hcm_pkg::LetterW];
   assign k10 = key_row_ff[1][0 +: hcm_pkg::LetterW];
   assign k11 = key_row_ff[1][hcm_pkg::LetterW +: hcm_pkg::LetterW];
   assign size_eff = hcm_pkg::eff_size(block_size_ff);

   function automatic logic [hcm_pkg::LetterW-1:0] neg26(input logic [hcm_pkg::LetterW-1:0] m);
      return (m == '0) ? '0 : (hcm_pkg::Mod26L - m);
   endfunction

   // Register writes; restart the settle count on every write.
   always_comb begin
      block_size_in = block_size_ff;
      decrypt_in    = decrypt_ff;
      key_row_in    = key_row_ff;
      settle_in     = (settle_ff != '0) ? (settle_ff - 1'b1) : settle_ff;
      if (csr_valid) begin
         settle_in = hcm_pkg::SettleW'(hcm_pkg::SettleCycles);
         unique case (csr_index) inside
            hcm_pkg::CSR_BLOCK_SIZE: begin
               block_size_in = csr_data[hcm_pkg::SizeW-1:0];
            end
            hcm_pkg::CSR_DECRYPT: begin
               decrypt_in = csr_data[0];
            end
            hcm_pkg::CSR_KEY_ROW0, hcm_pkg::CSR_KEY_ROW1,
            hcm_pkg::CSR_KEY_ROW2, hcm_pkg::CSR_KEY_ROW3: begin
               key_row_in[hcm_pkg::IdxW'(csr_index - hcm_pkg::CSR_KEY_ROW0)] = csr_data;
            end
            default: ;
         endcase
      end
   end

   // Stage 1: determinant products. Stage 2: determinant and its inverse.
   always_comb begin
      det_a_in = hcm_pkg::ProdW'(k00) * hcm_pkg::ProdW'(k11);
      det_b_in = hcm_pkg::ProdW'(k01) * hcm_pkg::ProdW'(k10);
      ra       = hcm_pkg::mod26(hcm_pkg::SumW'(det_a_ff));
      rb       = hcm_pkg::mod26(hcm_pkg::SumW'(det_b_ff));
      det_wrap = {1'b0, ra} + {1'b0, hcm_pkg::Mod26L} - {1'b0, rb};
      det      = (ra >= rb) ? (ra - rb) : det_wrap[hcm_pkg::LetterW-1:0];
      inv_in   = hcm_pkg::inv26(det);
   end

   // Stage 3: scaled adjugate products. Stage 4: reduce, sign and select.
   always_comb begin
      dprod_in[0][0] = hcm_pkg::ProdW'(inv_ff) * hcm_pkg::ProdW'(k11);
      dprod_in[0][1] = hcm_pkg::ProdW'(inv_ff) * hcm_pkg::ProdW'(k01);
      dprod_in[1][0] = hcm_pkg::ProdW'(inv_ff) * hcm_pkg::ProdW'(k10);
      dprod_in[1][1] = hcm_pkg::ProdW'(inv_ff) * hcm_pkg::ProdW'(k00);

      key_in.cols   = '0;
      key_in.status = hcm_pkg::STATUS_OK;
      if (!decrypt_ff) begin
         for (int i = 0; i < hcm_pkg::MaxBlock; i++) begin
            for (int j = 0; j < hcm_pkg::MaxBlock; j++) begin
               key_in.cols[i][j] =
                  hcm_pkg::red5(key_row_ff[j][hcm_pkg::LetterW*i +: hcm_pkg::LetterW]);
            end
         end
      end else begin
         key_in.cols[0][0] = hcm_pkg::mod26(hcm_pkg::SumW'(dprod_ff[0][0]));
         key_in.cols[1][0] = neg26(hcm_pkg::mod26(hcm_pkg::SumW'(dprod_ff[0][1])));
         key_in.cols[0][1] = neg26(hcm_pkg::mod26(hcm_pkg::SumW'(dprod_ff[1][0])));
         key_in.cols[1][1] = hcm_pkg::mod26(hcm_pkg::SumW'(dprod_ff[1][1]));
         if (size_eff != hcm_pkg::SizeW'(hcm_pkg::MinBlock)) begin
            key_in.status = hcm_pkg::STATUS_BAD_SIZE;
         end else if (inv_ff == '0) begin
            key_in.status = hcm_pkg::STATUS_NO_INVERSE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= hcm_pkg::SizeW'(hcm_pkg::MinBlock);
         decrypt_ff    <= 1'b0;
         key_row_ff    <= '0;
         settle_ff     <= hcm_pkg::SettleW'(hcm_pkg::SettleCycles);
      end else begin
         block_size_ff <= block_size_in;
         decrypt_ff    <= decrypt_in;
         key_row_ff    <= key_row_in;
         settle_ff     <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      det_a_ff <= det_a_in;
      det_b_ff <= det_b_in;
      inv_ff   <= inv_in;
      dprod_ff <= dprod_in;
      key_ff   <= key_in;
   end

   assign front_cfg.size = size_eff;
   assign front_cfg.hold = (settle_ff != '0) || csr_valid;
   assign key            = key_ff;

endmodule

@@ src/hcm_front.sv @@
// Letter collector: buffers letters and hands each completed block to the queue.
`include "assert_macros.svh"
module hcm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hcm_pkg::LetterW-1:0] req_letter,
   input  hcm_pkg::front_cfg_type      cfg,
   input  logic                        q_full,
   output logic                        push,
   output hcm_pkg::blk_type            push_blk
);

   logic [hcm_pkg::IdxW-1:0]                           fill_ff, fill_in;
   logic [hcm_pkg::MaxBlock-1:0][hcm_pkg::LetterW-1:0] lbuf_ff, lbuf_in;
   logic                                               accept;
   logic [hcm_pkg::SizeW-1:0]                          count;

   assign req_ready = !cfg.hold && !q_full;
   assign accept    = req_valid && req_ready;
   assign count     = hcm_pkg::SizeW'(fill_ff) + hcm_pkg::SizeW'(1);

   always_comb begin
      lbuf_in = lbuf_ff;
      fill_in = fill_ff;
      push    = 1'b0;
      if (accept) begin
         lbuf_in[fill_ff] = hcm_pkg::red5(req_letter);
         if (count >= cfg.size) begin
            push    = 1'b1;
            fill_in = '0;
         end else begin
            fill_in = count[hcm_pkg::IdxW-1:0];
         end
      end
   end

   assign push_blk.letters = lbuf_in;
   assign push_blk.size    = cfg.size;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      lbuf_ff <= lbuf_in;
   end

   `HCM_ASSERT_NEXT(a_fill_restart, clock, reset, push, fill_ff == '0)

endmodule

@@ src/hcm_queue.sv @@
// Two-entry block queue between the collector and the result generator.
`include "assert_macros.svh"
module hcm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hcm_pkg::blk_type push_blk,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output hcm_pkg::blk_type head
);

   hcm_pkg::blk_type            mem_ff [hcm_pkg::QueueDepth];
   logic [hcm_pkg::QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [hcm_pkg::QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [hcm_pkg::QCntW-1:0]   count_ff, count_in;

   assign full      = (count_ff == hcm_pkg::QCntW'(hcm_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_blk;
      end
   end

   `HCM_ASSERT(a_no_overflow, clock, reset, !(push && full))
   `HCM_ASSERT(a_no_underflow, clock, reset, !(pop && !not_empty))

endmodule

@@ src/hcm_back.sv @@
// Result generator: one mod-26 dot product per unstalled cycle into the output register.
`include "assert_macros.svh"
module hcm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  hcm_pkg::blk_type            q_head,
   output logic                        pop,
   input  hcm_pkg::key_type            key,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hcm_pkg::LetterW-1:0] rsp_out_letter,
   output logic                        rsp_last_of_block,
   output logic [1:0]                  rsp_status
);

   hcm_pkg::blk_type            cur_ff, cur_in;
   logic                        active_ff, active_in;
   logic [hcm_pkg::IdxW-1:0]    idx_ff, idx_in;

   logic                        a_valid_ff, a_valid_in;
   logic [hcm_pkg::SumW-1:0]    a_sum_ff, a_sum_in;
   logic                        a_last_ff, a_last_in;
   hcm_pkg::status_type         a_status_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hcm_pkg::LetterW-1:0] rsp_letter_ff, rsp_letter_in;
   logic                        rsp_last_ff;
   hcm_pkg::status_type         rsp_status_ff;

   logic                        out_en, a_en, issue, last_issue;
   logic [hcm_pkg::MaxBlock-1:0][hcm_pkg::LetterW-1:0] col;

   assign out_en     = !rsp_valid_ff || rsp_ready;
   assign a_en       = !a_valid_ff || out_en;
   assign issue      = active_ff && a_en;
   assign last_issue = issue && ((hcm_pkg::SizeW'(idx_ff) + hcm_pkg::SizeW'(1)) == cur_ff.size);
   assign pop        = q_valid && (!active_ff || last_issue);
   assign col        = key.cols[idx_ff];

   always_comb begin
      cur_in    = pop ? q_head : cur_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      if (pop) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (last_issue) begin
         active_in = 1'b0;
         idx_in    = '0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Dot product of the block's letters with the current key column.
   always_comb begin
      a_sum_in = '0;
      for (int j = 0; j < hcm_pkg::MaxBlock; j++) begin
         if (hcm_pkg::SizeW'(j) < cur_ff.size) begin
            a_sum_in = a_sum_in + hcm_pkg::SumW'(hcm_pkg::ProdW'(cur_ff.letters[j]) *
                                                 hcm_pkg::ProdW'(col[j]));
         end
      end
      a_last_in     = last_issue;
      a_valid_in    = a_en ? issue : a_valid_ff;
      rsp_valid_in  = out_en ? a_valid_ff : rsp_valid_ff;
      rsp_letter_in = (a_status_ff == hcm_pkg::STATUS_OK) ? hcm_pkg::mod26(a_sum_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (issue) begin
         a_sum_ff    <= a_sum_in;
         a_last_ff   <= a_last_in;
         a_status_ff <= key.status;
      end
      if (out_en && a_valid_ff) begin
         rsp_letter_ff <= rsp_letter_in;
         rsp_last_ff   <= a_last_ff;
         rsp_status_ff <= a_status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_letter    = rsp_letter_ff;
   assign rsp_last_of_block = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

   `HCM_ASSERT(a_letter_range, clock, reset, rsp_valid_ff |-> rsp_letter_ff < hcm_pkg::Mod26L)
   `HCM_ASSERT(a_error_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff != hcm_pkg::STATUS_OK |-> rsp_letter_ff == '0)

endmodule

@@ src/hill_cipher_mod26.sv @@
// Top level of the mod-26 block cipher: letter collector, block queue, result generator.
//
// Usage:
//  - req_ channel carries one letter index per request. Letters gather into blocks of
//    block_size (2..4; smaller values act as 2, larger as 4).
//  - When the last letter of a block is taken, block_size results leave on the rsp_
//    channel in order, the final one with rsp_last_of_block set. rsp_status flags a
//    decrypt at a size other than 2 or with a key whose determinant has no inverse mod 26;
//    those results carry letter 0.
//  - csr_ channel writes block_size, decrypt_mode and the four key rows by index; it
//    is always ready. Write only while no block is in flight.
//  - A completed block passes a queue entry and the current-block register; each
//    result then passes the sum and output registers, one per cycle unless stalled.
//  - Throughput: one request and one result per cycle, sustained unless the receiver
//    stalls, as a two-entry block queue lets collection of the next block overlap the
//    drain of the current one. The dot-product datapath emits one result per cycle.
//  - After reset and after every configuration write, req_ready stays low while the
//    key pipeline (determinant, inverse, adjugate) settles.
//  - When the receiver stalls, results hold in the output register, the queue fills,
//    and req_ready drops once the queue holds two complete blocks.
module hill_cipher_mod26 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hcm_pkg::LetterW-1:0] req_letter,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hcm_pkg::LetterW-1:0] rsp_out_letter,
   output logic                        rsp_last_of_block,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [hcm_pkg::CsrIdxW-1:0] csr_index,
   input  logic [hcm_pkg::RowW-1:0]    csr_data
);

   hcm_pkg::front_cfg_type front_cfg;
   hcm_pkg::key_type       key;
   hcm_pkg::blk_type       push_blk;
   hcm_pkg::blk_type       q_head;
   logic                   push;
   logic                   pop;
   logic                   q_full;
   logic                   q_valid;

   // Configuration writes never stall.
   assign csr_ready = 1'b1;

   // Hold config and derive the working matrix.
   hcm_keyprep u_keyprep (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .front_cfg (front_cfg),
      .key       (key)
   );

   // Gather letters; push complete blocks.
   hcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_letter (req_letter),
      .cfg        (front_cfg),
      .q_full     (q_full),
      .push       (push),
      .push_blk   (push_blk)
   );

   // Decouple collection from result drain.
   hcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_blk  (push_blk),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   // Produce one result per cycle from the head block unless the receiver stalls.
   hcm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .pop               (pop),
      .key               (key),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_letter    (rsp_out_letter),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_status        (rsp_status)
   );

endmodule
